### sv/ssup_pkg.sv
// Shared types, codes and reset values for the safety supervisor.
package ssup_pkg;

    typedef enum logic [1:0] {
        MODE_UPDATE    = 2'd0,
        MODE_SELF_TEST = 2'd1,
        MODE_TRIGGER   = 2'd2,
        MODE_REINIT    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_POWER_ON    = 3'd0,
        ST_SELF_TEST   = 3'd1,
        ST_OPERATIONAL = 3'd2,
        ST_WARNING     = 3'd3,
        ST_SAFE_STOP   = 3'd4,
        ST_ESTOP       = 3'd5,
        ST_SAFE_STATE  = 3'd6
    } t_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRITICAL_MASK  = 3'd0,
        CFG_SERIOUS_MASK   = 3'd1,
        CFG_SAFE_STOP_HOLD = 3'd2,
        CFG_ESTOP_BIT      = 3'd3,
        CFG_SELF_TEST_BIT  = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] HOLD_MS_RST       = 16'd1000;
    localparam logic [31:0] ESTOP_BIT_RST     = 32'd1;
    localparam logic [31:0] SELF_TEST_BIT_RST = 32'd2;

    typedef struct packed {
        logic [31:0] critical_mask;
        logic [31:0] serious_mask;
        logic [15:0] hold_ms;
        logic [31:0] estop_bit;
        logic [31:0] self_test_bit;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] now_ms;
        logic        estop;
        logic [31:0] fault_inputs;
        logic [31:0] cause_flags;
        logic        log_intact;
    } t_req;

    typedef struct packed {
        t_state      current_state;
        t_state      previous_state;
        logic [31:0] fault_mask;
        logic        safe_to_operate;
        logic        self_test_passed;
        logic        self_test_complete;
    } t_rsp;

endpackage

### sv/ssup_cfg.sv
// Configuration register file of the safety supervisor.
module ssup_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ssup_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssup_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output ssup_pkg::t_cfg                  o_cfg
);
    import ssup_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.critical_mask <= '0;
            r_cfg.serious_mask  <= '0;
            r_cfg.hold_ms       <= HOLD_MS_RST;
            r_cfg.estop_bit     <= ESTOP_BIT_RST;
            r_cfg.self_test_bit <= SELF_TEST_BIT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CRITICAL_MASK:  r_cfg.critical_mask <= i_cfg_wdata;
                CFG_SERIOUS_MASK:   r_cfg.serious_mask  <= i_cfg_wdata;
                CFG_SAFE_STOP_HOLD: r_cfg.hold_ms       <= i_cfg_wdata[15:0];
                CFG_ESTOP_BIT:      r_cfg.estop_bit     <= i_cfg_wdata;
                CFG_SELF_TEST_BIT:  r_cfg.self_test_bit <= i_cfg_wdata;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/ssup_core.sv
// Supervisor state registers and the single-step next-state logic.
module ssup_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  ssup_pkg::t_req i_req,
    input  ssup_pkg::t_cfg i_cfg,
    output ssup_pkg::t_rsp o_rsp
);
    import ssup_pkg::*;

    t_state      r_state, n_state;
    t_state      r_prev, n_prev;
    logic [31:0] r_fault, n_fault;
    logic [31:0] r_entry, n_entry;
    logic        r_flag, n_flag;
    logic        passed;
    logic [31:0] elapsed;
    logic        hold_done;
    logic        is_critical;
    logic        is_serious;
    logic        any_fault;

    assign elapsed     = i_req.now_ms - r_entry;  // wraps modulo 2^32
    assign hold_done   = elapsed >= {16'd0, i_cfg.hold_ms};
    assign is_critical = (i_req.fault_inputs & i_cfg.critical_mask) != 32'd0;
    assign is_serious  = (i_req.fault_inputs & i_cfg.serious_mask) != 32'd0;
    assign any_fault   = i_req.fault_inputs != 32'd0;

    always_comb begin
        n_state = r_state;
        n_prev  = r_prev;
        n_fault = r_fault;
        n_entry = r_entry;
        n_flag  = r_flag;
        passed  = 1'b0;
        case (i_req.mode)
            MODE_UPDATE: begin
                if (r_state == ST_SAFE_STATE) begin
                    // latched: hold everything
                end else if (i_req.estop) begin
                    if (r_state != ST_ESTOP) begin
                        n_prev  = r_state;
                        n_state = ST_ESTOP;
                        n_entry = i_req.now_ms;
                        n_fault = r_fault | i_cfg.estop_bit;
                    end
                end else if (is_critical) begin
                    n_prev  = r_state;
                    n_state = ST_SAFE_STATE;
                    n_entry = i_req.now_ms;
                    n_fault = r_fault | i_req.fault_inputs;
                end else begin
                    n_fault = i_req.fault_inputs;
                    case (r_state)
                        ST_OPERATIONAL: begin
                            if (is_serious) begin
                                n_prev  = r_state;
                                n_state = ST_SAFE_STOP;
                                n_entry = i_req.now_ms;
                            end else if (any_fault) begin
                                n_prev  = r_state;
                                n_state = ST_WARNING;
                                n_entry = i_req.now_ms;
                            end
                        end
                        ST_WARNING: begin
                            if (!any_fault) begin
                                n_prev  = r_state;
                                n_state = ST_OPERATIONAL;
                                n_entry = i_req.now_ms;
                            end else if (is_serious) begin
                                n_prev  = r_state;
                                n_state = ST_SAFE_STOP;
                                n_entry = i_req.now_ms;
                            end
                        end
                        ST_SAFE_STOP: begin
                            if (hold_done && !any_fault) begin
                                n_prev  = r_state;
                                n_state = ST_OPERATIONAL;
                                n_entry = i_req.now_ms;
                            end
                        end
                        ST_ESTOP: begin
                            n_prev  = r_state;
                            n_state = ST_SAFE_STOP;
                            n_entry = i_req.now_ms;
                        end
                        default: ;
                    endcase
                end
            end
            MODE_SELF_TEST: begin
                // passes through self test, so the previous state is always self test
                passed  = i_req.log_intact && !i_req.estop;
                n_prev  = ST_SELF_TEST;
                n_entry = i_req.now_ms;
                n_fault = r_fault
                        | (i_req.log_intact ? 32'd0 : i_cfg.self_test_bit)
                        | (i_req.estop      ? i_cfg.estop_bit : 32'd0);
                n_state = passed ? ST_OPERATIONAL : ST_SAFE_STATE;
                n_flag  = r_flag | passed;
            end
            MODE_TRIGGER: begin
                if (r_state != ST_SAFE_STATE) begin
                    n_prev  = r_state;
                    n_state = ST_ESTOP;
                    n_entry = i_req.now_ms;
                    n_fault = r_fault | i_req.cause_flags;
                end
            end
            MODE_REINIT: begin
                n_state = ST_POWER_ON;
                n_prev  = ST_POWER_ON;
                n_fault = '0;
                n_entry = i_req.now_ms;
                n_flag  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_POWER_ON;
            r_prev  <= ST_POWER_ON;
            r_fault <= '0;
            r_entry <= '0;
            r_flag  <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_fault <= n_fault;
            r_entry <= n_entry;
            r_flag  <= n_flag;
        end
    end

    always_comb begin
        o_rsp.current_state      = n_state;
        o_rsp.previous_state     = n_prev;
        o_rsp.fault_mask         = n_fault;
        o_rsp.safe_to_operate    = (n_state == ST_OPERATIONAL) || (n_state == ST_WARNING);
        o_rsp.self_test_passed   = passed;
        o_rsp.self_test_complete = n_flag;
    end

endmodule

### sv/safety_supervisor_fsm.sv
// Top level of the safety supervisor: request and result registers around the core.
// Sustains one request per clock while i_stall is low. A request is held until the result
// register can take it, then applied to the supervisor state; its result is shown from
// then on, held while o_valid and i_stall are high. The path from request register to
// result register is a single pass of the next-state logic. Fault masks, the safe-stop
// hold time and the fault bits set on emergency stop and on a failed log check come from
// the write-only register port; write them only while no request is in flight.
module safety_supervisor_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [ssup_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssup_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_mode,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_estop,
    input  logic [31:0]                     i_fault_inputs,
    input  logic [31:0]                     i_cause_flags,
    input  logic                            i_log_intact,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_current_state,
    output logic [2:0]                      o_previous_state,
    output logic [31:0]                     o_fault_mask,
    output logic                            o_safe_to_operate,
    output logic                            o_self_test_passed,
    output logic                            o_self_test_complete
);
    import ssup_pkg::*;

    t_cfg cfg;
    t_rsp rsp;
    t_req r_req;
    t_rsp r_rsp;
    logic r_in_valid;
    logic r_out_valid;
    logic adv;

    ssup_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ssup_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_req   (r_req),
        .i_cfg   (cfg),
        .o_rsp   (rsp)
    );

    // advance the held request unless the result register is full and stalled
    assign adv     = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req.mode         <= t_mode'(i_mode);
            r_req.now_ms       <= i_now_ms;
            r_req.estop        <= i_estop;
            r_req.fault_inputs <= i_fault_inputs;
            r_req.cause_flags  <= i_cause_flags;
            r_req.log_intact   <= i_log_intact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp <= rsp;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_current_state      = r_rsp.current_state;
    assign o_previous_state     = r_rsp.previous_state;
    assign o_fault_mask         = r_rsp.fault_mask;
    assign o_safe_to_operate    = r_rsp.safe_to_operate;
    assign o_self_test_passed   = r_rsp.self_test_passed;
    assign o_self_test_complete = r_rsp.self_test_complete;

endmodule

### sv/ssup_checker.sv
// Port-level checks for the safety supervisor, bound to the top level.
module ssup_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_current_state,
    input logic [2:0]  o_previous_state,
    input logic [31:0] o_fault_mask,
    input logic        o_safe_to_operate,
    input logic        o_self_test_passed,
    input logic        o_self_test_complete
);
    import ssup_pkg::*;

    a_safe_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_safe_to_operate ==
            ((o_current_state == ST_OPERATIONAL) || (o_current_state == ST_WARNING)))
        else $error("safe_to_operate disagrees with state");

    a_pass_lands_operational: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_self_test_passed) |->
            (o_current_state == ST_OPERATIONAL) && (o_previous_state == ST_SELF_TEST)
            && o_self_test_complete)
        else $error("passed self test did not land in operational");

    a_self_test_transient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_current_state != ST_SELF_TEST)
        else $error("self test shown as a resting state");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_current_state)
            && $stable(o_previous_state) && $stable(o_fault_mask))
        else $error("stalled result changed");

endmodule

bind safety_supervisor_fsm ssup_checker u_ssup_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_current_state      (o_current_state),
    .o_previous_state     (o_previous_state),
    .o_fault_mask         (o_fault_mask),
    .o_safe_to_operate    (o_safe_to_operate),
    .o_self_test_passed   (o_self_test_passed),
    .o_self_test_complete (o_self_test_complete)
);

### bench/safety_supervisor_fsm_check.sv
// Scoreboard for the safety supervisor: predicts each status from accepted requests and compares.
module safety_supervisor_fsm_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ssup_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssup_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [1:0]                      i_mode,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_estop,
    input  logic [31:0]                     i_fault_inputs,
    input  logic [31:0]                     i_cause_flags,
    input  logic                            i_log_intact,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_stall,
    input  logic [2:0]                      i_current_state,
    input  logic [2:0]                      i_previous_state,
    input  logic [31:0]                     i_fault_mask,
    input  logic                            i_safe_to_operate,
    input  logic                            i_self_test_passed,
    input  logic                            i_self_test_complete,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic [6:0]                      o_states_seen
);
    import ssup_pkg::*;

    t_cfg        regs;
    t_state      cur_st;
    t_state      prev_st;
    logic [31:0] faults;
    logic [31:0] entered_at;
    logic        tested;
    t_rsp        status_q[$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_states_seen = '0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        o_fail_count++;
        // keep the log short when the design is badly broken
        if (o_fail_count <= 30) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    task automatic move_to(input t_state nxt, input logic [31:0] at);
        prev_st    = cur_st;
        cur_st     = nxt;
        entered_at = at;
    endtask

    task automatic predict_status(input t_req r, output t_rsp s);
        logic [31:0] elapsed;
        logic        passed;
        passed  = 1'b0;
        elapsed = r.now_ms - entered_at;
        case (r.mode)
            MODE_UPDATE: begin
                // the safe state ignores updates entirely
                if (cur_st != ST_SAFE_STATE) begin
                    if (r.estop) begin
                        if (cur_st != ST_ESTOP) begin
                            move_to(ST_ESTOP, r.now_ms);
                            faults |= regs.estop_bit;
                        end
                    end else if ((r.fault_inputs & regs.critical_mask) != 32'd0) begin
                        move_to(ST_SAFE_STATE, r.now_ms);
                        faults |= r.fault_inputs;
                    end else begin
                        faults = r.fault_inputs;
                        case (cur_st)
                            ST_OPERATIONAL: begin
                                if ((r.fault_inputs & regs.serious_mask) != 32'd0) begin
                                    move_to(ST_SAFE_STOP, r.now_ms);
                                end else if (r.fault_inputs != 32'd0) begin
                                    move_to(ST_WARNING, r.now_ms);
                                end
                            end
                            ST_WARNING: begin
                                if (r.fault_inputs == 32'd0) begin
                                    move_to(ST_OPERATIONAL, r.now_ms);
                                end else if ((r.fault_inputs & regs.serious_mask) != 32'd0) begin
                                    move_to(ST_SAFE_STOP, r.now_ms);
                                end
                            end
                            ST_SAFE_STOP: begin
                                // elapsed time wraps with the tick
                                if (elapsed >= {16'd0, regs.hold_ms} && r.fault_inputs == 32'd0) begin
                                    move_to(ST_OPERATIONAL, r.now_ms);
                                end
                            end
                            ST_ESTOP: move_to(ST_SAFE_STOP, r.now_ms);
                            default: ;
                        endcase
                    end
                end
            end
            MODE_SELF_TEST: begin
                move_to(ST_SELF_TEST, r.now_ms);
                passed = r.log_intact && !r.estop;
                if (!r.log_intact) faults |= regs.self_test_bit;
                if (r.estop) faults |= regs.estop_bit;
                if (passed) begin
                    tested = 1'b1;
                    move_to(ST_OPERATIONAL, r.now_ms);
                end else begin
                    move_to(ST_SAFE_STATE, r.now_ms);
                end
            end
            MODE_TRIGGER: begin
                if (cur_st != ST_SAFE_STATE) begin
                    move_to(ST_ESTOP, r.now_ms);
                    faults |= r.cause_flags;
                end
            end
            MODE_REINIT: begin
                cur_st     = ST_POWER_ON;
                prev_st    = ST_POWER_ON;
                faults     = 32'd0;
                entered_at = r.now_ms;
                tested     = 1'b0;
            end
            default: ;
        endcase
        s.current_state      = cur_st;
        s.previous_state     = prev_st;
        s.fault_mask         = faults;
        s.safe_to_operate    = (cur_st == ST_OPERATIONAL || cur_st == ST_WARNING);
        s.self_test_passed   = passed;
        s.self_test_complete = tested;
    endtask

    always @(posedge i_clk) begin : watch
        t_req seen;
        t_rsp want;
        if (!i_rst_n) begin
            regs.critical_mask = 32'd0;
            regs.serious_mask  = 32'd0;
            regs.hold_ms       = HOLD_MS_RST;
            regs.estop_bit     = ESTOP_BIT_RST;
            regs.self_test_bit = SELF_TEST_BIT_RST;
            cur_st     = ST_POWER_ON;
            prev_st    = ST_POWER_ON;
            faults     = 32'd0;
            entered_at = 32'd0;
            tested     = 1'b0;
            status_q.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CRITICAL_MASK:  regs.critical_mask = i_cfg_wdata;
                    CFG_SERIOUS_MASK:   regs.serious_mask  = i_cfg_wdata;
                    CFG_SAFE_STOP_HOLD: regs.hold_ms       = i_cfg_wdata[15:0];
                    CFG_ESTOP_BIT:      regs.estop_bit     = i_cfg_wdata;
                    CFG_SELF_TEST_BIT:  regs.self_test_bit = i_cfg_wdata;
                    default: ;
                endcase
            end
            // compare before queuing: a status leaving now belongs to an older request
            if (i_rsp_valid && !i_rsp_stall) begin
                o_states_seen[i_current_state] = 1'b1;
                if (status_q.size() == 0) begin
                    flag_mismatch("status with no request waiting", i_fault_mask, 32'd0);
                end else begin
                    want = status_q.pop_front();
                    o_pending--;
                    if (i_current_state != want.current_state)
                        flag_mismatch("current_state", 32'(i_current_state),
                                      32'(want.current_state));
                    if (i_previous_state != want.previous_state)
                        flag_mismatch("previous_state", 32'(i_previous_state),
                                      32'(want.previous_state));
                    if (i_fault_mask != want.fault_mask)
                        flag_mismatch("fault_mask", i_fault_mask, want.fault_mask);
                    if (i_safe_to_operate != want.safe_to_operate)
                        flag_mismatch("safe_to_operate", 32'(i_safe_to_operate),
                                      32'(want.safe_to_operate));
                    if (i_self_test_passed != want.self_test_passed)
                        flag_mismatch("self_test_passed", 32'(i_self_test_passed),
                                      32'(want.self_test_passed));
                    if (i_self_test_complete != want.self_test_complete)
                        flag_mismatch("self_test_complete", 32'(i_self_test_complete),
                                      32'(want.self_test_complete));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                seen.mode         = t_mode'(i_mode);
                seen.now_ms       = i_now_ms;
                seen.estop        = i_estop;
                seen.fault_inputs = i_fault_inputs;
                seen.cause_flags  = i_cause_flags;
                seen.log_intact   = i_log_intact;
                predict_status(seen, want);
                status_q.push_back(want);
                o_pending++;
            end
        end
    end

endmodule

### bench/safety_supervisor_fsm_test.sv
// Testbench top for the safety supervisor: drives requests, register writes and back-pressure.
module safety_supervisor_fsm_test;
    import ssup_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 210;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    t_req                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [2:0]            rsp_cur;
    logic [2:0]            rsp_prev;
    logic [31:0]           rsp_faults;
    logic                  rsp_safe;
    logic                  rsp_passed;
    logic                  rsp_complete;

    int         fail_count;
    int         pending;
    logic [6:0] states_seen;
    logic       calm      = 1'b0;   // no idling on either side while set
    int         stall_run = 0;
    int         cycles    = 0;
    int         settings  = 0;
    int         mode_count[4];

    // register values as last written, used only to shape the stimulus
    logic [31:0] crit_now;
    logic [31:0] serious_now;
    logic [15:0] hold_now;
    logic [31:0] tick;

    always #10 clk = ~clk;

    safety_supervisor_fsm uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_wdata         (cfg_wdata),
        .i_valid             (req_valid),
        .o_stall             (req_stall),
        .i_mode              (req.mode),
        .i_now_ms            (req.now_ms),
        .i_estop             (req.estop),
        .i_fault_inputs      (req.fault_inputs),
        .i_cause_flags       (req.cause_flags),
        .i_log_intact        (req.log_intact),
        .o_valid             (rsp_valid),
        .i_stall             (rsp_stall),
        .o_current_state     (rsp_cur),
        .o_previous_state    (rsp_prev),
        .o_fault_mask        (rsp_faults),
        .o_safe_to_operate   (rsp_safe),
        .o_self_test_passed  (rsp_passed),
        .o_self_test_complete(rsp_complete)
    );

    safety_supervisor_fsm_check u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_wdata         (cfg_wdata),
        .i_req_valid         (req_valid),
        .i_req_stall         (req_stall),
        .i_mode              (req.mode),
        .i_now_ms            (req.now_ms),
        .i_estop             (req.estop),
        .i_fault_inputs      (req.fault_inputs),
        .i_cause_flags       (req.cause_flags),
        .i_log_intact        (req.log_intact),
        .i_rsp_valid         (rsp_valid),
        .i_rsp_stall         (rsp_stall),
        .i_current_state     (rsp_cur),
        .i_previous_state    (rsp_prev),
        .i_fault_mask        (rsp_faults),
        .i_safe_to_operate   (rsp_safe),
        .i_self_test_passed  (rsp_passed),
        .i_self_test_complete(rsp_complete),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_states_seen       (states_seen)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d statuses outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // status back-pressure: runs of stall and no stall, mostly short
    always @(negedge clk) begin
        if (!rst_n || calm) begin
            rsp_stall = 1'b0;
            stall_run = 0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else if (rsp_stall) begin
            rsp_stall = 1'b0;
            stall_run = $urandom_range(0, 12);
        end else begin
            rsp_stall = 1'b1;
            stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 40);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic put_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_wr_en = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        @(negedge clk);
    endtask

    // call only with nothing in flight
    task automatic write_regs(input logic [31:0] crit, input logic [31:0] serious,
                              input logic [15:0] hold, input logic [31:0] estop_bit,
                              input logic [31:0] test_bit);
        put_reg(CFG_CRITICAL_MASK, crit);
        put_reg(CFG_SERIOUS_MASK, serious);
        put_reg(CFG_SAFE_STOP_HOLD, {16'd0, hold});
        put_reg(CFG_ESTOP_BIT, estop_bit);
        put_reg(CFG_SELF_TEST_BIT, test_bit);
        cfg_wr_en   = 1'b0;
        crit_now    = crit;
        serious_now = serious;
        hold_now    = hold;
        settings++;
    endtask

    // hold valid until the request is taken, then idle for the gap
    task automatic put(input t_mode m, input logic [31:0] now, input logic estop,
                       input logic [31:0] flt, input logic [31:0] cause, input logic log_ok);
        int gap;
        gap                = gap_len();
        req.mode           = m;
        req.now_ms         = now;
        req.estop          = estop;
        req.fault_inputs   = flt;
        req.cause_flags    = cause;
        req.log_intact     = log_ok;
        req_valid          = 1'b1;
        mode_count[m]++;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        req_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_faults();
        logic [31:0] benign;
        logic [31:0] harsh;
        int          r;
        r      = $urandom_range(0, 99);
        benign = $urandom & $urandom & ~crit_now & ~serious_now;
        harsh  = serious_now & ~crit_now & $urandom;
        if (harsh == 32'd0) harsh = serious_now & ~crit_now;
        if (r < 45) return 32'd0;
        if (r < 70) return benign;
        if (r < 85) return harsh | benign;
        if (r < 92) return (crit_now & $urandom) | benign;
        return $urandom;
    endfunction

    task automatic random_phase(input int n);
        int          r;
        t_mode       m;
        logic        estop;
        logic        log_ok;
        logic [31:0] cause;
        for (int i = 0; i < n; i++) begin
            calm = (i >= 40 && i < 70);
            // let every status come back before going on
            if (i == n / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 70) tick += $urandom_range(0, 20);
            else if (r < 90) tick += $urandom_range(0, hold_now + 50);
            else if (r < 97) tick += $urandom_range(60000, 70000);
            else tick = $urandom;
            r = $urandom_range(0, 99);
            if (r < 75) m = MODE_UPDATE;
            else if (r < 87) m = MODE_SELF_TEST;
            else if (r < 95) m = MODE_TRIGGER;
            else m = MODE_REINIT;
            estop  = (m == MODE_SELF_TEST) ? ($urandom_range(0, 99) < 10)
                                           : ($urandom_range(0, 99) < 7);
            log_ok = ($urandom_range(0, 99) < 85);
            r      = $urandom_range(0, 9);
            cause  = (r == 0) ? 32'd0 : (r < 3) ? $urandom : ($urandom & $urandom);
            put(m, tick, estop, pick_faults(), cause, log_ok);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_regs(32'hF000_0000, 32'h0F00_0000, 16'd50, 32'h0000_0001, 32'h0000_0002);
        put(MODE_UPDATE,    32'd0,   1'b0, 32'h0000_0010, 32'd0, 1'b1); // power-on keeps faults only
        put(MODE_SELF_TEST, 32'd5,   1'b0, 32'd0, 32'd0, 1'b1);
        put(MODE_UPDATE,    32'd10,  1'b0, 32'h0000_0010, 32'd0, 1'b1); // warning
        put(MODE_UPDATE,    32'd11,  1'b0, 32'd0, 32'd0, 1'b1);
        put(MODE_UPDATE,    32'd100, 1'b0, 32'h0100_0000, 32'd0, 1'b1); // serious: safe stop
        put(MODE_UPDATE,    32'd149, 1'b0, 32'd0, 32'd0, 1'b1);         // one tick short of hold
        put(MODE_UPDATE,    32'd150, 1'b0, 32'd0, 32'd0, 1'b1);         // hold reached
        put(MODE_UPDATE,    32'd160, 1'b0, 32'h0000_0004, 32'd0, 1'b0);
        put(MODE_UPDATE,    32'd161, 1'b0, 32'h0200_0004, 32'd0, 1'b0); // warning to safe stop
        put(MODE_UPDATE,    32'd170, 1'b1, 32'd0, 32'd0, 1'b1);
        put(MODE_UPDATE,    32'd171, 1'b1, 32'd0, 32'd0, 1'b1);         // estop already active
        put(MODE_UPDATE,    32'd172, 1'b0, 32'd0, 32'd0, 1'b1);
        put(MODE_UPDATE,    32'd173, 1'b0, 32'h8000_0000, 32'd0, 1'b1); // critical latches safe state
        put(MODE_TRIGGER,   32'd174, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1); // dropped in safe state
        put(MODE_UPDATE,    32'd175, 1'b1, 32'd0, 32'd0, 1'b1);
        put(MODE_SELF_TEST, 32'd176, 1'b0, 32'd0, 32'd0, 1'b0);         // failing test keeps flag
        put(MODE_SELF_TEST, 32'd177, 1'b1, 32'd0, 32'd0, 1'b1);
        put(MODE_SELF_TEST, 32'd178, 1'b0, 32'd0, 32'd0, 1'b1);         // leaves safe state
        put(MODE_TRIGGER,   32'd179, 1'b0, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b0);
        put(MODE_REINIT,    32'hFFFF_FFF0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        put(MODE_SELF_TEST, 32'hFFFF_FFF4, 1'b0, 32'd0, 32'd0, 1'b1);
        put(MODE_UPDATE,    32'hFFFF_FFFF, 1'b0, 32'h0400_0000, 32'd0, 1'b1);
        put(MODE_UPDATE,    32'h0000_0030, 1'b0, 32'd0, 32'd0, 1'b1);   // across the wrap, short
        put(MODE_UPDATE,    32'h0000_0031, 1'b0, 32'd0, 32'd0, 1'b1);   // across the wrap, enough
        put(MODE_REINIT,    32'd0, 1'b0, 32'd0, 32'd0, 1'b0);
        put(MODE_UPDATE,    32'd1, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1);   // critical even in power-on
        drain();

        tick = 32'd200;
        write_regs(32'h8000_0000, 32'h0F00_0000, 16'd0, 32'h0000_0001, 32'h0000_0002);
        random_phase(PHASE_ITEMS);
        drain();

        write_regs(32'd0, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        random_phase(PHASE_ITEMS);
        drain();

        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1000, 32'd0, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);
        drain();

        write_regs(32'd1 << $urandom_range(0, 31), $urandom & $urandom & $urandom,
                   16'($urandom_range(1, 200)), $urandom, $urandom);
        random_phase(PHASE_ITEMS);
        drain();

        // start just short of the tick wrap
        tick = 32'hFFFF_0000;
        write_regs(32'h0000_0001, 32'hFFFF_0000, 16'd300, 32'h0000_8000, 32'h4000_0000);
        random_phase(PHASE_ITEMS);
        drain();

        write_regs($urandom & $urandom & $urandom & $urandom, $urandom & $urandom,
                   16'($urandom_range(0, 65535)), $urandom, $urandom);
        random_phase(PHASE_ITEMS);
        drain();
        repeat (8) @(negedge clk);

        $display("ran %0d requests (%0d update, %0d self test, %0d trigger, %0d reinit)",
                 mode_count[MODE_UPDATE] + mode_count[MODE_SELF_TEST]
                 + mode_count[MODE_TRIGGER] + mode_count[MODE_REINIT],
                 mode_count[MODE_UPDATE], mode_count[MODE_SELF_TEST],
                 mode_count[MODE_TRIGGER], mode_count[MODE_REINIT]);
        $display("under %0d register settings; states seen in statuses %b (power-on at bit 0)",
                 settings, states_seen);
        if (pending != 0) $display("%0d statuses never returned", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
